@@ hdl/jddn_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jddn_pkg
// Shared types, constants and constant-divisor helpers for the Julian day
// number unit.
// ---------------------------------------------------------------------------
package jddn_pkg;

   localparam logic [13:0] YEAR_MAX        = 14'd9999;
   localparam logic [13:0] EPOCH_YEARS     = 14'd4800;
   localparam logic [23:0] JDN_BIAS        = 24'd32083;
   localparam logic [23:0] CIVIL_BIAS      = 24'd32082;
   // day number of March 22 plus 13, less the year terms
   localparam logic [23:0] EASTER_BIAS     = 24'd32048;
   localparam logic [16:0] SHIFT_YEAR_LO   = 17'd4800;
   localparam logic [16:0] SHIFT_YEAR_HI   = 17'd14799;

   // Stage-two word handed from the front end to the back stages
   typedef struct packed {
      logic        bad;
      logic [13:0] year;
      logic [22:0] jdn;
      logic [24:0] sj;
      logic [1:0]  b0;
      logic [2:0]  c0;
      logic [4:0]  d0;
      logic [1:0]  b1;
      logic [2:0]  c1;
      logic [4:0]  d1;
      logic [22:0] base0;
   } front_type;

   // Remainder by 19 of a year, reciprocal multiply
   function automatic logic [4:0] mod19_f(input logic [13:0] x);
      logic [30:0] p;
      logic [10:0] q;
      logic [13:0] r;
      p = 31'(x) * 31'd55189;
      q = p[30:20];
      r = x - 14'(14'(q) * 14'd19);
      return r[4:0];
   endfunction

   // Remainder by 7 of a 14-bit value
   function automatic logic [2:0] mod7_f(input logic [13:0] x);
      logic [27:0] p;
      logic [11:0] q;
      logic [13:0] r;
      p = 28'(x) * 28'd9363;
      q = p[27:16];
      r = x - 14'(14'(q) * 14'd7);
      return r[2:0];
   endfunction

   // Remainder by 30 of a 9-bit value
   function automatic logic [4:0] mod30_f(input logic [8:0] x);
      logic [20:0] p;
      logic [4:0]  q;
      logic [8:0]  r;
      p = 21'(x) * 21'd2185;
      q = p[20:16];
      r = x - 9'(9'(q) * 9'd30);
      return r[4:0];
   endfunction

   // Quotient by 5 of an 11-bit value
   function automatic logic [8:0] div5_f(input logic [10:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'd13108;
      return p[24:16];
   endfunction

endpackage

@@ hdl/julian_date_day_number_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// julian_date_day_number_unit
// Julian-calendar date to day number, weekday, date shifted by an offset
// and the following Easter date, one date per cycle unless the output is held.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake            | word
//   req_     | in        | req_valid/req_ready  | year, month, day, day offset
//   rsp_     | out       | rsp_valid/rsp_ready  | day number, weekday, shifted
//            |           |                      | date, Easter date, error flag
//
// Six register stages. A new date may enter every cycle in which the output word
// is not held.
// The whole pipeline advances together; it holds while rsp_valid is high
// and rsp_ready is low, so req_ready follows rsp_ready or an empty output.
// Reset clears the stage valid bits only.
// ---------------------------------------------------------------------------
module julian_date_day_number_unit import jddn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [13:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [22:0] req_day_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [22:0] rsp_day_number,
   output logic [2:0]  rsp_weekday,
   output logic [13:0] rsp_shifted_year,
   output logic [3:0]  rsp_shifted_month,
   output logic [4:0]  rsp_shifted_day,
   output logic [13:0] rsp_easter_year,
   output logic [2:0]  rsp_easter_month,
   output logic [4:0]  rsp_easter_day,
   output logic        rsp_error_flag
);

   logic        en;
   logic [5:0]  valid_ff, valid_in;
   front_type   st2;
   logic        neg;
   logic [15:0] q;
   logic [8:0]  e;
   logic [3:0]  k;
   logic [2:0]  wk;
   logic        later;
   logic [2:0]  emonth;
   logic [4:0]  eday;
   logic        bad3_ff, bad4_ff, bad5_ff;
   logic [13:0] year3_ff, year4_ff, year5_ff;
   logic [22:0] jdn3_ff, jdn4_ff, jdn5_ff;
   logic        k10;
   logic [8:0]  t5;
   logic [8:0]  sd9;
   logic [3:0]  sm;
   logic [16:0] sy17;
   logic [16:0] sy_off;
   logic        civ_err, east_err, err;
   logic [22:0] dn_ff;
   logic [2:0]  wk_ff;
   logic [13:0] sy_ff, ey_ff;
   logic [3:0]  sm_ff;
   logic [4:0]  sd_ff, ed_ff;
   logic [2:0]  em_ff;
   logic        err_ff;

   // Advance every stage together unless the output word is held
   assign en        = !valid_ff[5] || rsp_ready;
   assign req_ready = en;
   assign valid_in  = {valid_ff[4:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   jddn_front u_front (
      .clock      (clock),
      .en         (en),
      .year_in    (req_year_in),
      .month_in   (req_month_in),
      .day_in     (req_day_in),
      .day_offset (req_day_offset),
      .st2        (st2)
   );

   jddn_civil u_civil (
      .clock (clock),
      .en    (en),
      .sj    (st2.sj),
      .neg   (neg),
      .q     (q),
      .e     (e),
      .k     (k)
   );

   jddn_calendar u_calendar (
      .clock   (clock),
      .en      (en),
      .st2     (st2),
      .weekday (wk),
      .later   (later),
      .emonth  (emonth),
      .eday    (eday)
   );

   // Carry the input check, year and day number alongside the back stages
   always_ff @(posedge clock) begin
      if (en) begin
         bad3_ff  <= st2.bad;
         year3_ff <= st2.year;
         jdn3_ff  <= st2.jdn;
         bad4_ff  <= bad3_ff;
         year4_ff <= year3_ff;
         jdn4_ff  <= jdn3_ff;
         bad5_ff  <= bad4_ff;
         year5_ff <= year4_ff;
         jdn5_ff  <= jdn4_ff;
      end
   end

   // Finish the shifted date, range-check both years
   always_comb begin
      k10      = (k >= 4'd10);
      t5       = div5_f(11'(k) * 11'd153 + 11'd2);
      sd9      = e - t5 + 9'd1;
      sm       = k10 ? k - 4'd9 : k + 4'd3;
      sy17     = 17'(q) + 17'(k10);
      sy_off   = sy17 - SHIFT_YEAR_LO;
      civ_err  = neg || (sy17 < SHIFT_YEAR_LO) || (sy17 > SHIFT_YEAR_HI);
      east_err = later && (year5_ff == YEAR_MAX);
      err      = bad5_ff || civ_err || east_err;
   end

   // Load the output word, zeroed on error
   always_ff @(posedge clock) begin
      if (en) begin
         err_ff <= err;
         if (err) begin
            dn_ff <= '0;
            wk_ff <= '0;
            sy_ff <= '0;
            sm_ff <= '0;
            sd_ff <= '0;
            ey_ff <= '0;
            em_ff <= '0;
            ed_ff <= '0;
         end else begin
            dn_ff <= jdn5_ff;
            wk_ff <= wk;
            sy_ff <= sy_off[13:0];
            sm_ff <= sm;
            sd_ff <= sd9[4:0];
            ey_ff <= year5_ff + 14'(later);
            em_ff <= emonth;
            ed_ff <= eday;
         end
      end
   end

   assign rsp_valid         = valid_ff[5];
   assign rsp_day_number    = dn_ff;
   assign rsp_weekday       = wk_ff;
   assign rsp_shifted_year  = sy_ff;
   assign rsp_shifted_month = sm_ff;
   assign rsp_shifted_day   = sd_ff;
   assign rsp_easter_year   = ey_ff;
   assign rsp_easter_month  = em_ff;
   assign rsp_easter_day    = ed_ff;
   assign rsp_error_flag    = err_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_day_number) &&
                                  $stable(rsp_error_flag))
      else $error("output word changed while stalled");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_day_number == 23'd0 &&
                                      rsp_easter_month == 3'd0 && rsp_shifted_year == 14'd0)
      else $error("error word carries data");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error_flag |-> rsp_weekday < 3'd7)
      else $error("weekday out of range");

   a_easter_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error_flag |-> rsp_easter_month >= 3'd3 && rsp_easter_month <= 3'd5)
      else $error("Easter month out of range");

endmodule

@@ hdl/jddn_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jddn_front
// Stages one and two: field check, day number, shifted day number and the
// Easter epact terms for the input year and the year after.
// ---------------------------------------------------------------------------
module jddn_front import jddn_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [13:0] year_in,
   input  logic [3:0]  month_in,
   input  logic [4:0]  day_in,
   input  logic [22:0] day_offset,
   output front_type   st2
);

   logic        bad_in, bad_ff;
   logic        a_mar;
   logic [3:0]  mm;
   logic [13:0] yp;
   logic [13:0] year_ff;
   logic [4:0]  day_ff;
   logic [22:0] off_ff;
   logic [8:0]  t1_in, t1_ff;
   logic [13:0] yy_in, yy_ff;
   logic [13:0] ye_in, ye_ff;
   logic [4:0]  a0_in, a0_ff, a1_in, a1_ff;
   logic [2:0]  c0_in, c0_ff, c1_in, c1_ff;
   logic [23:0] jdn_w, base_w;
   front_type   st2_in, st2_ff;

   // Check fields and split the date into shifted-year terms
   always_comb begin
      bad_in = (year_in > YEAR_MAX) || (month_in == 4'd0) || (month_in > 4'd12) ||
               (day_in == 5'd0);
      a_mar  = (month_in < 4'd3);
      mm     = a_mar ? month_in + 4'd9 : month_in - 4'd3;
      yy_in  = year_in + EPOCH_YEARS - 14'(a_mar);
      ye_in  = year_in + EPOCH_YEARS;
      t1_in  = div5_f(11'(mm) * 11'd153 + 11'd2);
      yp     = year_in + 14'd1;
      a0_in  = mod19_f(year_in);
      a1_in  = mod19_f(yp);
      c0_in  = mod7_f(year_in);
      c1_in  = mod7_f(yp);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bad_ff  <= bad_in;
         year_ff <= year_in;
         day_ff  <= day_in;
         off_ff  <= day_offset;
         t1_ff   <= t1_in;
         yy_ff   <= yy_in;
         ye_ff   <= ye_in;
         a0_ff   <= a0_in;
         a1_ff   <= a1_in;
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
      end
   end

   // Sum the day number, add the offset, reduce the epacts
   always_comb begin
      jdn_w  = 24'(day_ff) + 24'(t1_ff) + 24'(yy_ff) * 24'd365 + 24'(yy_ff[13:2]) - JDN_BIAS;
      base_w = 24'(ye_ff) * 24'd365 + 24'(ye_ff[13:2]) - EASTER_BIAS;
      st2_in.bad   = bad_ff;
      st2_in.year  = year_ff;
      st2_in.jdn   = jdn_w[22:0];
      st2_in.sj    = {2'b00, jdn_w[22:0]} + {{2{off_ff[22]}}, off_ff};
      st2_in.b0    = year_ff[1:0];
      st2_in.b1    = year_ff[1:0] + 2'd1;
      st2_in.c0    = c0_ff;
      st2_in.c1    = c1_ff;
      st2_in.d0    = mod30_f(9'(a0_ff) * 9'd19 + 9'd15);
      st2_in.d1    = mod30_f(9'(a1_ff) * 9'd19 + 9'd15);
      st2_in.base0 = base_w[22:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st2_ff <= st2_in;
      end
   end

   assign st2 = st2_ff;

endmodule

@@ hdl/jddn_civil.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jddn_civil
// Stages three to five: inverse day number, giving the four-year cycle
// count, day of cycle year and month index of the shifted date.
// ---------------------------------------------------------------------------
module jddn_civil import jddn_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [24:0] sj,
   output logic        neg,
   output logic [15:0] q,
   output logic [8:0]  e,
   output logic [3:0]  k
);

   logic [23:0] c_in, c3_ff;
   logic [51:0] qp;
   logic [15:0] q3_ff, q4_ff, q5_ff;
   logic        neg3_ff, neg4_ff, neg5_ff;
   logic [26:0] tp;
   logic [23:0] ediff;
   logic [8:0]  e4_ff, e5_ff;
   logic [10:0] kx;
   logic [21:0] kp;
   logic [3:0]  k5_ff;

   // Quotient of (4c + 3) by 1461 through a reciprocal
   always_comb begin
      c_in = sj[23:0] + CIVIL_BIAS;
      qp   = 52'({c_in, 2'b11}) * 52'd47035919;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff   <= c_in;
         q3_ff   <= qp[51:36];
         neg3_ff <= sj[24];
      end
   end

   // Day within the cycle year
   always_comb begin
      tp    = 27'(q3_ff) * 27'd1461;
      ediff = c3_ff - 24'(tp[26:2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e4_ff   <= ediff[8:0];
         q4_ff   <= q3_ff;
         neg4_ff <= neg3_ff;
      end
   end

   // Month index, quotient of (5e + 2) by 153
   always_comb begin
      kx = 11'(e4_ff) * 11'd5 + 11'd2;
      kp = 22'(kx) * 22'd1714;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k5_ff   <= kp[21:18];
         e5_ff   <= e4_ff;
         q5_ff   <= q4_ff;
         neg5_ff <= neg4_ff;
      end
   end

   assign neg = neg5_ff;
   assign q   = q5_ff;
   assign e   = e5_ff;
   assign k   = k5_ff;

endmodule

@@ hdl/jddn_calendar.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jddn_calendar
// Stages three to five: weekday of the input date and the Easter month and
// day, moving to the next year when the date lies after this year's Easter.
// ---------------------------------------------------------------------------
module jddn_calendar import jddn_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  front_type   st2,
   output logic [2:0]  weekday,
   output logic        later,
   output logic [2:0]  emonth,
   output logic [4:0]  eday
);

   logic [2:0]  e0_in, e1_in, e0_ff, e1_ff;
   logic [4:0]  d0_ff, d1_ff;
   logic [22:0] base_ff, jdn_ff;
   logic [46:0] wp_in, wp_ff;
   logic [20:0] wq;
   logic [22:0] rem;
   logic [23:0] ej0;
   logic        later_in, later4_ff, later5_ff;
   logic [6:0]  v_in, v_ff;
   logic [2:0]  wk4_ff, wk5_ff;
   logic [2:0]  em_in, em_ff;
   logic [4:0]  ed_in, ed_ff;

   // Weekday terms and the Easter offset for both years
   always_comb begin
      e0_in = mod7_f(14'({st2.b0, 1'b0}) + 14'({st2.c0, 2'b00}) +
                     14'(st2.d0) * 14'd6 + 14'd6);
      e1_in = mod7_f(14'({st2.b1, 1'b0}) + 14'({st2.c1, 2'b00}) +
                     14'(st2.d1) * 14'd6 + 14'd6);
      wp_in = 47'(st2.jdn) * 47'd9586981;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff   <= e0_in;
         e1_ff   <= e1_in;
         d0_ff   <= st2.d0;
         d1_ff   <= st2.d1;
         base_ff <= st2.base0;
         jdn_ff  <= st2.jdn;
         wp_ff   <= wp_in;
      end
   end

   // Compare with this year's Easter and pick the March offset
   always_comb begin
      wq       = wp_ff[46:26];
      rem      = jdn_ff - 23'(23'(wq) * 23'd7);
      ej0      = 24'(base_ff) + 24'(d0_ff) + 24'(e0_ff);
      later_in = ({1'b0, jdn_ff} > ej0);
      v_in     = later_in ? 7'd35 + 7'(d1_ff) + 7'(e1_ff)
                          : 7'd35 + 7'(d0_ff) + 7'(e0_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wk4_ff    <= rem[2:0];
         later4_ff <= later_in;
         v_ff      <= v_in;
      end
   end

   // Fold the March offset into March, April or May
   always_comb begin
      if (v_ff <= 7'd31) begin
         em_in = 3'd3;
         ed_in = v_ff[4:0];
      end else if (v_ff <= 7'd61) begin
         em_in = 3'd4;
         ed_in = 5'(v_ff - 7'd31);
      end else begin
         em_in = 3'd5;
         ed_in = 5'(v_ff - 7'd61);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wk5_ff    <= wk4_ff;
         later5_ff <= later4_ff;
         em_ff     <= em_in;
         ed_ff     <= ed_in;
      end
   end

   assign weekday = wk5_ff;
   assign later   = later5_ff;
   assign emonth  = em_ff;
   assign eday    = ed_ff;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives Julian-calendar dates with day offsets into the date unit and
// checks day number, weekday, shifted date, Easter date and error flag
// against a behavioural calendar model, with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [22:0] day_number;
      logic [2:0]  weekday;
      logic [13:0] shifted_year;
      logic [3:0]  shifted_month;
      logic [4:0]  shifted_day;
      logic [13:0] easter_year;
      logic [2:0]  easter_month;
      logic [4:0]  easter_day;
      logic        error_flag;
   } date_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [13:0] req_year_in;
   logic [3:0]  req_month_in;
   logic [4:0]  req_day_in;
   logic [22:0] req_day_offset;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [22:0] rsp_day_number;
   logic [2:0]  rsp_weekday;
   logic [13:0] rsp_shifted_year;
   logic [3:0]  rsp_shifted_month;
   logic [4:0]  rsp_shifted_day;
   logic [13:0] rsp_easter_year;
   logic [2:0]  rsp_easter_month;
   logic [4:0]  rsp_easter_day;
   logic        rsp_error_flag;

   date_result_type expected_dates[$];
   int          mismatch_count;
   int          cycle_count;
   bit          idle_enable;
   bit          hold_off_request;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LATENCY     = 6;

   julian_date_day_number_unit i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // day number of a Julian date
   function automatic longint julian_day(longint y, longint m, longint d);
      longint a, yy, mm;
      a  = (14 - m) / 12;
      yy = y + 4800 - a;
      mm = m + 12 * a - 3;
      return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - 32083;
   endfunction

   // Julian date of a non-negative day number
   function automatic void calendar_date(input longint j, output longint y,
                                         output longint m, output longint d);
      longint c, q, e, k;
      c = j + 32082;
      q = (4 * c + 3) / 1461;
      e = c - (1461 * q) / 4;
      k = (5 * e + 2) / 153;
      d = e - (153 * k + 2) / 5 + 1;
      m = k + 3 - 12 * (k / 10);
      y = q - 4800 + (k / 10);
   endfunction

   function automatic longint easter_day_number(longint y);
      longint dd, ee;
      dd = (19 * (y % 19) + 15) % 30;
      ee = (2 * (y % 4) + 4 * (y % 7) + 6 * dd + 6) % 7;
      return julian_day(y, 3, 22) + dd + ee + 13;
   endfunction

   function automatic date_result_type predict_dates(logic [13:0] yr, logic [3:0] mo,
                                                     logic [4:0] dy, logic [22:0] off);
      date_result_type r;
      longint jdn, sj, sy, sm, sd, ej, ey, em, ed;
      bit bad;
      r = '0;
      bad = 1'b0;
      if (yr > 9999 || mo < 1 || mo > 12 || dy < 1) begin
         r.error_flag = 1'b1;
         return r;
      end
      jdn = julian_day(yr, mo, dy);
      sj = jdn + longint'($signed(off));
      if (sj < 0) begin
         bad = 1'b1;
      end else begin
         calendar_date(sj, sy, sm, sd);
         if (sy < 0 || sy > 9999) bad = 1'b1;
      end
      ey = yr;
      ej = easter_day_number(ey);
      if (jdn > ej) begin
         ey = ey + 1;
         if (ey > 9999) bad = 1'b1;
         else ej = easter_day_number(ey);
      end
      if (bad) begin
         r.error_flag = 1'b1;
         return r;
      end
      calendar_date(ej, ey, em, ed);
      r.day_number    = 23'(jdn);
      r.weekday       = 3'(jdn % 7);
      r.shifted_year  = 14'(sy);
      r.shifted_month = 4'(sm);
      r.shifted_day   = 5'(sd);
      r.easter_year   = 14'(ey);
      r.easter_month  = 3'(em);
      r.easter_day    = 5'(ed);
      return r;
   endfunction

   // offer one word, wait for acceptance; starts and ends at a falling edge
   task automatic send_date(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy,
                            logic [22:0] off);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_year_in    <= yr;
      req_month_in   <= mo;
      req_day_in     <= dy;
      req_day_offset <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_dates.insert(expected_dates.size(), predict_dates(yr, mo, dy, off));
      @(negedge clock);
   endtask

   function automatic logic [22:0] random_offset();
      case ($urandom_range(0, 3))
         0: return 23'($signed($urandom_range(0, 800)) - 400);
         1: return 23'($signed($urandom_range(0, 7320000)) - 3660000);
         2: return 23'($urandom);
         default: return 23'($signed($urandom_range(0, 80000)) - 40000);
      endcase
   endfunction

   task automatic test_directed();
      send_date(14'd0, 4'd1, 5'd1, 23'd0);
      send_date(14'd9999, 4'd12, 5'd31, 23'd0);
      send_date(14'd10000, 4'd6, 5'd1, 23'd0);
      send_date(14'h3FFF, 4'd6, 5'd1, 23'd0);
      send_date(14'd2000, 4'd0, 5'd1, 23'd0);
      send_date(14'd2000, 4'd13, 5'd1, 23'd0);
      send_date(14'd2000, 4'd15, 5'd1, 23'd0);
      send_date(14'd2000, 4'd5, 5'd0, 23'd0);
      send_date(14'd2000, 4'd2, 5'd30, 23'd1);
      send_date(14'd2000, 4'd2, 5'd31, 23'h7FFFFF);
      send_date(14'd0, 4'd1, 5'd1, 23'h7FFFFF);
      send_date(14'd0, 4'd1, 5'd1, 23'h400000);
      send_date(14'd9999, 4'd1, 5'd1, 23'h3FFFFF);
      send_date(14'd5000, 4'd6, 5'd15, 23'($signed(-3660000)));
      send_date(14'd5000, 4'd6, 5'd15, 23'd3660000);
      send_date(14'd9999, 4'd1, 5'd1, 23'd3000);
      send_date(14'd9999, 4'd3, 5'd1, 23'd0);
      send_date(14'd9999, 4'd5, 5'd31, 23'd0);
      send_date(14'd1, 4'd1, 5'd1, 23'h7FFFFF);
      // Dates after this year's Easter move on to the next year's Easter
      send_date(14'd2024, 4'd5, 5'd5, 23'd0);
      send_date(14'd2024, 4'd5, 5'd6, 23'd0);
      send_date(14'd1700, 4'd4, 5'd25, 23'd365);
   endtask

   task automatic test_random(int count);
      logic [13:0] yr;
      logic [3:0]  mo;
      logic [4:0]  dy;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            yr = 14'($urandom);
            mo = 4'($urandom);
            dy = 5'($urandom);
         end else begin
            yr = ($urandom_range(0, 5) == 0) ? 14'($urandom_range(9990, 9999))
                                             : 14'($urandom_range(0, 9999));
            mo = 4'($urandom_range(1, 12));
            dy = 5'($urandom_range(1, 31));
         end
         send_date(yr, mo, dy, random_offset());
      end
   endtask

   task automatic test_back_pressure();
      hold_off_request = 1'b1;
      test_random(30);
      hold_off_request = 1'b0;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (40) @(negedge clock);
            rsp_ready <= 1'b1;
            wait (!hold_off_request);
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted word with the oldest expectation
   initial begin
      date_result_type exp_r, got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_day_number, rsp_weekday, rsp_shifted_year, rsp_shifted_month,
                    rsp_shifted_day, rsp_easter_year, rsp_easter_month, rsp_easter_day,
                    rsp_error_flag};
            if (expected_dates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected word at cycle %0d", cycle_count);
            end else begin
               exp_r = expected_dates.pop_front();
               if (got !== exp_r) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch cycle %0d: expected %p, got %p",
                              cycle_count, exp_r, got);
               end
            end
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL julian_date_day_number_unit");
            $finish;
         end
      end
   end

   initial begin
      int drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_year_in = '0;
      req_month_in = '0;
      req_day_in = '0;
      req_day_offset = '0;
      mismatch_count = 0;
      idle_enable = 1'b1;
      hold_off_request = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_back_pressure();
      test_random(1300);
      idle_enable = 1'b0;
      test_random(200);
      req_valid <= 1'b0;
      drain = 0;
      while (expected_dates.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && expected_dates.size() == 0) begin
         $display("PASS julian_date_day_number_unit");
      end else begin
         $display("FAIL julian_date_day_number_unit");
      end
      $finish;
   end

endmodule
